// ===== hdl/icmp_erb_pkg.sv =====
// Shared constants, control word types and the microcode table for the
// ICMP echo request builder. No dependencies.
package icmp_erb_pkg;

  localparam int MAX_PAYLOAD = 56;
  localparam int HDR_BYTES   = 8;
  localparam int SUM_W       = 22;  // 49 words of 16 bits never pass 2^22
  localparam int POS_W       = 7;
  localparam int STEP_W      = 4;
  localparam int IDX_W       = 4;   // 16 address words
  localparam int CIDX_W      = 8;

  localparam logic [7:0] TYPE_V4         = 8'd8;
  localparam logic [7:0] TYPE_V6         = 8'd128;
  localparam logic [7:0] NEXT_HDR_ICMPV6 = 8'd58;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] REG_IPV6_MODE   = 8'd0;
  localparam logic [CIDX_W-1:0] REG_ECHO_ID     = 8'd1;
  localparam logic [CIDX_W-1:0] REG_PAYLOAD_LEN = 8'd2;
  localparam logic [CIDX_W-1:0] REG_SRC_HIGH    = 8'd3;
  localparam logic [CIDX_W-1:0] REG_SRC_LOW     = 8'd4;
  localparam logic [CIDX_W-1:0] REG_DST_HIGH    = 8'd5;
  localparam logic [CIDX_W-1:0] REG_DST_LOW     = 8'd6;

  // datapath operations
  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_ADD   = 3'd2;
  localparam logic [2:0] OP_FOLD  = 3'd3;
  localparam logic [2:0] OP_FINAL = 3'd4;
  localparam logic [2:0] OP_EMIT  = 3'd5;

  // adder word sources
  localparam logic [2:0] SRC_ADDR = 3'd0;
  localparam logic [2:0] SRC_LEN  = 3'd1;
  localparam logic [2:0] SRC_NH   = 3'd2;
  localparam logic [2:0] SRC_TYPE = 3'd3;
  localparam logic [2:0] SRC_ID   = 3'd4;
  localparam logic [2:0] SRC_SEQ  = 3'd5;
  localparam logic [2:0] SRC_PAY  = 3'd6;

  // jump conditions: jump to target when true, else fall through
  localparam logic [2:0] J_NEVER     = 3'd0;
  localparam logic [2:0] J_ALWAYS    = 3'd1;
  localparam logic [2:0] J_NOIN      = 3'd2;
  localparam logic [2:0] J_V4        = 3'd3;
  localparam logic [2:0] J_IDX_MORE  = 3'd4;
  localparam logic [2:0] J_PAY_MORE  = 3'd5;
  localparam logic [2:0] J_EMIT_WAIT = 3'd6;

  // step addresses
  localparam logic [STEP_W-1:0] S_IDLE  = 4'd0;
  localparam logic [STEP_W-1:0] S_MODE  = 4'd1;
  localparam logic [STEP_W-1:0] S_ADDR  = 4'd2;
  localparam logic [STEP_W-1:0] S_LEN   = 4'd3;
  localparam logic [STEP_W-1:0] S_NH    = 4'd4;
  localparam logic [STEP_W-1:0] S_HDR0  = 4'd5;
  localparam logic [STEP_W-1:0] S_HDR1  = 4'd6;
  localparam logic [STEP_W-1:0] S_HDR2  = 4'd7;
  localparam logic [STEP_W-1:0] S_PAY   = 4'd8;
  localparam logic [STEP_W-1:0] S_FOLD1 = 4'd9;
  localparam logic [STEP_W-1:0] S_FOLD2 = 4'd10;
  localparam logic [STEP_W-1:0] S_FINAL = 4'd11;
  localparam logic [STEP_W-1:0] S_EMIT  = 4'd12;
  localparam logic [STEP_W-1:0] S_RET   = 4'd13;

  typedef struct packed {
    logic [2:0]        op;
    logic [2:0]        src;
    logic [2:0]        cond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic in_acc;
    logic v4;
    logic idx_more;
    logic pay_more;
    logic emit_wait;
  } flags_t;

  function automatic ctrl_t ucode_rom(input logic [STEP_W-1:0] step);
    ctrl_t cw;
    cw = '{op: OP_NONE, src: SRC_ADDR, cond: J_ALWAYS, target: S_IDLE};
    case (step)
      S_IDLE:  cw = '{op: OP_START, src: SRC_ADDR, cond: J_NOIN,      target: S_IDLE};
      S_MODE:  cw = '{op: OP_NONE,  src: SRC_ADDR, cond: J_V4,        target: S_HDR0};
      S_ADDR:  cw = '{op: OP_ADD,   src: SRC_ADDR, cond: J_IDX_MORE,  target: S_ADDR};
      S_LEN:   cw = '{op: OP_ADD,   src: SRC_LEN,  cond: J_NEVER,     target: S_IDLE};
      S_NH:    cw = '{op: OP_ADD,   src: SRC_NH,   cond: J_NEVER,     target: S_IDLE};
      S_HDR0:  cw = '{op: OP_ADD,   src: SRC_TYPE, cond: J_NEVER,     target: S_IDLE};
      S_HDR1:  cw = '{op: OP_ADD,   src: SRC_ID,   cond: J_NEVER,     target: S_IDLE};
      S_HDR2:  cw = '{op: OP_ADD,   src: SRC_SEQ,  cond: J_NEVER,     target: S_IDLE};
      S_PAY:   cw = '{op: OP_ADD,   src: SRC_PAY,  cond: J_PAY_MORE,  target: S_PAY};
      S_FOLD1: cw = '{op: OP_FOLD,  src: SRC_ADDR, cond: J_NEVER,     target: S_IDLE};
      S_FOLD2: cw = '{op: OP_FOLD,  src: SRC_ADDR, cond: J_NEVER,     target: S_IDLE};
      S_FINAL: cw = '{op: OP_FINAL, src: SRC_ADDR, cond: J_NEVER,     target: S_IDLE};
      S_EMIT:  cw = '{op: OP_EMIT,  src: SRC_ADDR, cond: J_EMIT_WAIT, target: S_EMIT};
      S_RET:   cw = '{op: OP_NONE,  src: SRC_ADDR, cond: J_ALWAYS,    target: S_IDLE};
      default: cw = '{op: OP_NONE,  src: SRC_ADDR, cond: J_ALWAYS,    target: S_IDLE};
    endcase
    return cw;
  endfunction

endpackage

// ===== hdl/icmp_echo_request_builder_core.sv =====
// ICMP echo request builder: one sequence number in, one echo request out, a byte per transaction.
// After an input transaction the microcode drives the checksum adder one word per step: in IPv6
// mode the pseudo-header (addresses, length, next header) first, then the header words and the
// payload, then the folds and the final checksum. Bytes then leave one per cycle while out_stall is low;
// the next request is taken once the sequencer is back in idle after the last byte is loaded. Synchronous reset
// returns configuration and datapath registers to their defaults (payload length 56) and the sequencer to idle.
module icmp_echo_request_builder_core import icmp_erb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [15:0]       in_sequence_req,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_packet_byte,
  output logic              out_last_byte,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [63:0]       cfg_data
);

  ctrl_t  ctrl;
  flags_t flags;
  logic   idle;

  logic        ipv6_mode_r;
  logic [15:0] echo_id_r;
  logic [5:0]  payload_length_r;
  logic [63:0] src_high_r, src_low_r, dst_high_r, dst_low_r;

  logic [15:0]      seq_r;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [15:0]      csum_r;
  logic [IDX_W-1:0] idx_r;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic             out_last_r;

  logic [5:0]       plen_sat;
  logic [POS_W-1:0] total;
  logic [255:0]     addr_cat;
  logic [15:0]      word;
  logic [7:0]       pay_lo;
  logic [16:0]      fold;
  logic             in_acc, add_en, load, at_last;
  logic [7:0]       cur_byte;

  icmp_erb_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl),
    .idle  (idle)
  );

  assign in_stall  = !idle;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_packet_byte = out_byte_r;
  assign out_last_byte   = out_last_r;

  assign plen_sat = (payload_length_r > 6'(MAX_PAYLOAD)) ? 6'(MAX_PAYLOAD) : payload_length_r;
  assign total    = POS_W'(HDR_BYTES) + {1'b0, plen_sat};
  assign addr_cat = {src_high_r, src_low_r, dst_high_r, dst_low_r};

  // odd tail byte pads with zero on the right
  assign pay_lo = (POS_W'(pos_r + 1'b1) == total) ? 8'd0 : 8'(pos_r + 1'b1);

  always_comb begin
    case (ctrl.src)
      SRC_ADDR: word = addr_cat[{~idx_r, 4'hF} -: 16];
      SRC_LEN:  word = {9'd0, total};
      SRC_NH:   word = {8'd0, NEXT_HDR_ICMPV6};
      SRC_TYPE: word = {ipv6_mode_r ? TYPE_V6 : TYPE_V4, 8'd0};
      SRC_ID:   word = echo_id_r;
      SRC_SEQ:  word = seq_r;
      SRC_PAY:  word = {8'(pos_r), pay_lo};
      default:  word = 16'd0;
    endcase
  end

  always_comb begin
    case (pos_r)
      7'd0:    cur_byte = ipv6_mode_r ? TYPE_V6 : TYPE_V4;
      7'd1:    cur_byte = 8'd0;
      7'd2:    cur_byte = csum_r[15:8];
      7'd3:    cur_byte = csum_r[7:0];
      7'd4:    cur_byte = echo_id_r[15:8];
      7'd5:    cur_byte = echo_id_r[7:0];
      7'd6:    cur_byte = seq_r[15:8];
      7'd7:    cur_byte = seq_r[7:0];
      default: cur_byte = 8'(pos_r);
    endcase
  end

  assign add_en  = (ctrl.op == OP_ADD) && ((ctrl.src != SRC_PAY) || (pos_r < total));
  assign fold    = 17'(sum_r[15:0]) + 17'(sum_r[SUM_W-1:16]);
  assign load    = (ctrl.op == OP_EMIT) && (!out_valid_r || !out_stall);
  assign at_last = (POS_W'(pos_r + 1'b1) == total);

  assign flags.in_acc    = in_acc;
  assign flags.v4        = !ipv6_mode_r;
  assign flags.idx_more  = (idx_r != {IDX_W{1'b1}});
  assign flags.pay_more  = (POS_W'(pos_r + 7'd2) < total);
  assign flags.emit_wait = !(load && at_last);

  always_comb begin
    sum_nxt = sum_r;
    pos_nxt = pos_r;
    case (ctrl.op)
      OP_START: sum_nxt = '0;
      OP_ADD: begin
        if (add_en) sum_nxt = sum_r + SUM_W'(word);
        if (ctrl.src == SRC_SEQ) pos_nxt = POS_W'(HDR_BYTES);
        if (ctrl.src == SRC_PAY) pos_nxt = POS_W'(pos_r + 7'd2);
      end
      OP_FOLD:  sum_nxt = SUM_W'(fold);
      OP_FINAL: pos_nxt = '0;
      OP_EMIT:  if (load) pos_nxt = POS_W'(pos_r + 1'b1);
      default:  sum_nxt = sum_r;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ipv6_mode_r      <= 1'b0;
      echo_id_r        <= '0;
      payload_length_r <= 6'(MAX_PAYLOAD);
      src_high_r       <= '0;
      src_low_r        <= '0;
      dst_high_r       <= '0;
      dst_low_r        <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IPV6_MODE:   ipv6_mode_r      <= cfg_data[0];
        REG_ECHO_ID:     echo_id_r        <= cfg_data[15:0];
        REG_PAYLOAD_LEN: payload_length_r <= cfg_data[5:0];
        REG_SRC_HIGH:    src_high_r       <= cfg_data;
        REG_SRC_LOW:     src_low_r        <= cfg_data;
        REG_DST_HIGH:    dst_high_r       <= cfg_data;
        REG_DST_LOW:     dst_low_r        <= cfg_data;
        default:         ipv6_mode_r      <= ipv6_mode_r;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      csum_r      <= '0;
      pos_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sum_r <= sum_nxt;
      pos_r <= pos_nxt;
      if (ctrl.op == OP_START) begin
        idx_r <= '0;
      end else if (add_en && ctrl.src == SRC_ADDR) begin
        idx_r <= idx_r + 1'b1;
      end
      if (ctrl.op == OP_FINAL) csum_r <= ~(fold[15:0] + 16'(fold[16]));
      if (!out_valid_r || !out_stall) out_valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) seq_r <= in_sequence_req;
    if (load) begin
      out_byte_r <= cur_byte;
      out_last_r <= at_last;
    end
  end

endmodule

// ===== hdl/icmp_erb_seq.sv =====
// Microcode sequencer: step counter, control word table, conditional jumps.
// Depends on icmp_erb_pkg.
module icmp_erb_seq import icmp_erb_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  flags_t flags,
  output ctrl_t  ctrl,
  output logic   idle
);

  logic [STEP_W-1:0] step_r, step_nxt;
  logic              jmp;

  assign ctrl = ucode_rom(step_r);
  assign idle = (step_r == S_IDLE);

  always_comb begin
    case (ctrl.cond)
      J_NEVER:     jmp = 1'b0;
      J_ALWAYS:    jmp = 1'b1;
      J_NOIN:      jmp = !flags.in_acc;
      J_V4:        jmp = flags.v4;
      J_IDX_MORE:  jmp = flags.idx_more;
      J_PAY_MORE:  jmp = flags.pay_more;
      J_EMIT_WAIT: jmp = flags.emit_wait;
      default:     jmp = 1'b1;
    endcase
    step_nxt = jmp ? ctrl.target : step_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for icmp_echo_request_builder_core: predicts every echo request byte
// from a local copy of the registers and compares it with each output transaction.
// Depends on icmp_erb_pkg (hdl/icmp_erb_pkg.sv) and the core RTL.
module tb_top;
  import icmp_erb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 500_000;
  localparam int MAX_REPORTS = 100;
  localparam logic [CIDX_W-1:0] REG_UNUSED_LO = REG_DST_LOW + 1'b1;
  localparam logic [CIDX_W-1:0] REG_UNUSED_HI = '1;

  typedef struct packed {
    logic [7:0] pkt_byte;
    logic       last;
  } echo_byte_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [15:0]       in_sequence_req = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [7:0]        out_packet_byte;
  logic              out_last_byte;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [63:0]       cfg_data = '0;

  // register copy used for prediction
  logic        cur_v6;
  logic [15:0] cur_id;
  logic [5:0]  cur_plen;
  logic [63:0] cur_addr [0:3];

  echo_byte_t expected_bytes [$];
  echo_byte_t want;
  int error_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req = 0;
  int hold_left = 0;

  icmp_echo_request_builder_core uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sequence_req (in_sequence_req),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_packet_byte (out_packet_byte),
    .out_last_byte   (out_last_byte),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_val);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got,
               exp_val);
  endtask

  function automatic void predict_echo_request(input logic [15:0] seq_num);
    logic [7:0]  pkt [0:63];
    logic [31:0] word_sum;
    logic [15:0] csum;
    int          plen;
    int          total;
    echo_byte_t  b;
    plen  = (cur_plen > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(cur_plen);
    total = HDR_BYTES + plen;
    pkt[0] = cur_v6 ? TYPE_V6 : TYPE_V4;
    pkt[1] = 8'h00;
    pkt[2] = 8'h00;
    pkt[3] = 8'h00;
    pkt[4] = cur_id[15:8];
    pkt[5] = cur_id[7:0];
    pkt[6] = seq_num[15:8];
    pkt[7] = seq_num[7:0];
    for (int i = HDR_BYTES; i < total; i++) pkt[i] = 8'(i);
    word_sum = '0;
    if (cur_v6) begin
      // pseudo-header: both addresses, 32-bit length, next header
      for (int a = 0; a < 4; a++)
        for (int w = 0; w < 4; w++) word_sum += 32'(cur_addr[a][16*w +: 16]);
      word_sum += 32'(total);
      word_sum += 32'(NEXT_HDR_ICMPV6);
    end
    for (int i = 0; i + 1 < total; i += 2) word_sum += 32'({pkt[i], pkt[i+1]});
    if (total % 2 == 1) word_sum += 32'({pkt[total-1], 8'h00});
    for (int k = 0; k < 3; k++) word_sum = 32'(word_sum[15:0]) + 32'(word_sum[31:16]);
    csum   = ~word_sum[15:0];
    pkt[2] = csum[15:8];
    pkt[3] = csum[7:0];
    for (int i = 0; i < total; i++) begin
      b.pkt_byte = pkt[i];
      b.last     = (i == total - 1);
      expected_bytes.push_back(b);
    end
  endfunction

  // result checker: one expected byte per output transaction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch("unexpected byte", 64'(out_packet_byte), 0);
      end else begin
        want = expected_bytes.pop_front();
        if (out_packet_byte !== want.pkt_byte)
          report_mismatch("packet_byte", 64'(out_packet_byte), 64'(want.pkt_byte));
        if (out_last_byte !== want.last)
          report_mismatch("last_byte", 64'(out_last_byte), 64'(want.last));
      end
    end
  end

  // receiver: random stall, or a counted hold-off when requested
  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (recv_idle_pct != 0) && ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  task automatic send_request(input logic [15:0] seq_num);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid        <= 1'b1;
    in_sequence_req <= seq_num;
    do @(posedge clk); while (in_stall);
    predict_echo_request(seq_num);
  endtask

  // drop valid and wait for every predicted byte to come out
  task automatic drain_packets();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CIDX_W-1:0] idx, input logic [63:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_IPV6_MODE:   cur_v6      = data[0];
      REG_ECHO_ID:     cur_id      = data[15:0];
      REG_PAYLOAD_LEN: cur_plen    = data[5:0];
      REG_SRC_HIGH:    cur_addr[0] = data;
      REG_SRC_LOW:     cur_addr[1] = data;
      REG_DST_HIGH:    cur_addr[2] = data;
      REG_DST_LOW:     cur_addr[3] = data;
      default: ;
    endcase
  endtask

  task automatic program_config(input logic [63:0] mode, input logic [63:0] id,
                                input logic [63:0] plen, input logic [63:0] sh,
                                input logic [63:0] sl, input logic [63:0] dh,
                                input logic [63:0] dl);
    cfg_write(REG_IPV6_MODE, mode);
    cfg_write(REG_ECHO_ID, id);
    cfg_write(REG_PAYLOAD_LEN, plen);
    cfg_write(REG_SRC_HIGH, sh);
    cfg_write(REG_SRC_LOW, sl);
    cfg_write(REG_DST_HIGH, dh);
    cfg_write(REG_DST_LOW, dl);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [63:0] rand_quad();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom(), $urandom()};
  endfunction

  task automatic randomize_config();
    logic [63:0] plen;
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0:       plen = {$urandom(), $urandom()};  // upper bits dropped, may saturate
      1:       plen = 64'($urandom_range(MAX_PAYLOAD + 1, 63));
      2:       plen = 0;
      3:       plen = MAX_PAYLOAD;
      default: plen = 64'($urandom_range(0, MAX_PAYLOAD));
    endcase
    program_config({$urandom(), $urandom()}, {$urandom(), $urandom()}, plen,
                   rand_quad(), rand_quad(), rand_quad(), rand_quad());
    if ($urandom_range(0, 3) == 0) begin
      cfg_write(CIDX_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)),
                {$urandom(), $urandom()});
      @(negedge clk);
      cfg_valid <= 1'b0;
    end
  endtask

  task automatic test_reset_defaults();
    // IPv4, id 0, full payload straight out of reset
    send_request(16'h0000);
    send_request(16'hFFFF);
    drain_packets();
  endtask

  task automatic test_header_fields();
    // addresses are set but must be ignored in IPv4 mode
    program_config(0, 64'hFFFF, 4, '1, 64'h0123_4567_89AB_CDEF, '1, '1);
    send_request(16'h00FF);
    send_request(16'hFF00);
    send_request(16'h8001);
    drain_packets();
    program_config(0, 0, 5, 0, 0, 0, 0);
    send_request(16'h7FFE);
    drain_packets();
  endtask

  task automatic test_payload_lengths();
    logic [63:0] lens [0:6];
    lens = '{0, 1, 2, 55, 57, 63, 64'hFFFF_FFFF_FFFF_FFC0};
    foreach (lens[i]) begin
      program_config(0, 64'h1234, lens[i], 0, 0, 0, 0);
      send_request(16'($urandom()));
      drain_packets();
    end
  endtask

  task automatic test_ipv6_checksum();
    // all-ones addresses push the word sum highest
    program_config(1, 64'hFFFF, MAX_PAYLOAD, '1, '1, '1, '1);
    send_request(16'hFFFF);
    drain_packets();
    // zero addresses still count in the pseudo-header length and next header
    program_config(1, 0, 0, 0, 0, 0, 0);
    send_request(16'h0000);
    drain_packets();
    program_config(1, 64'hA5A5, 1, 64'hFE80_0000_0000_0000, 64'h0000_0000_0000_0001,
                   64'hFE80_0000_0000_0000, 64'h0211_22FF_FE33_4455);
    send_request(16'h1357);
    drain_packets();
  endtask

  task automatic test_register_decode();
    // writes past the last register index leave everything as it is
    cfg_write(REG_UNUSED_LO, '1);
    cfg_write(REG_UNUSED_HI, '1);
    // wide values: only the register's own bits count
    cfg_write(REG_IPV6_MODE, 64'hFFFF_FFFF_FFFF_FFFE);
    cfg_write(REG_ECHO_ID, 64'hDEAD_BEEF_0012_3456);
    cfg_write(REG_PAYLOAD_LEN, 64'h8000_0000_0000_0047);
    @(negedge clk);
    cfg_valid <= 1'b0;
    send_request(16'h2468);
    drain_packets();
    cfg_write(REG_IPV6_MODE, 64'h8000_0000_0000_0003);
    @(negedge clk);
    cfg_valid <= 1'b0;
    send_request(16'h1111);
    drain_packets();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_config(1, 64'h4321, 33, rand_quad(), rand_quad(), rand_quad(), rand_quad());
    hold_req = 400;
    repeat (5) send_request(16'($urandom()));
    drain_packets();
  endtask

  task automatic test_random_traffic(input int n_items, input int s_pct, input int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < n_items; i++) begin
      if (i % 15 == 0) begin
        drain_packets();
        randomize_config();
      end
      send_request(16'($urandom_range(0, 65535)));
    end
    drain_packets();
  endtask

  initial begin
    cur_v6   = 1'b0;
    cur_id   = '0;
    cur_plen = 6'(MAX_PAYLOAD);
    foreach (cur_addr[i]) cur_addr[i] = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_header_fields();
    test_payload_lengths();
    test_ipv6_checksum();
    test_register_decode();
    test_backpressure();
    test_random_traffic(90, 34, 50);
    test_random_traffic(90, 50, 34);
    test_random_traffic(90, 0, 0);

    repeat (64) @(posedge clk);
    if (expected_bytes.size() != 0)
      report_mismatch("bytes never received", 64'(expected_bytes.size()), 0);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
